/* hdl/dipid_pkg.sv */
package dipid_pkg;

	localparam int unsigned DUTY_LIMIT = 9900;

	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int ACC_W   = 32;
	localparam int DUTY_W  = 14;
	localparam int FRAC_W  = 8;
	localparam int SUM_W   = ACC_W + FRAC_W + 1;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [2:0] {
		REG_LEFT_TARGET  = 3'd0,
		REG_RIGHT_TARGET = 3'd1,
		REG_LEFT_KP      = 3'd2,
		REG_LEFT_KI      = 3'd3,
		REG_LEFT_KD      = 3'd4,
		REG_RIGHT_KP     = 3'd5,
		REG_RIGHT_KI     = 3'd6,
		REG_RIGHT_KD     = 3'd7
	} reg_idx_t;

	// products of one motor, kept apart until the accumulate stage
	typedef struct packed {
		logic signed [32:0] p;
		logic signed [31:0] i;
		logic signed [33:0] d;
	} prod_t;

	typedef struct packed {
		logic [DUTY_W-1:0] fwd;
		logic [DUTY_W-1:0] rev;
	} duty_t;

	function automatic prod_t pid_products(
		input logic signed [SPEED_W-1:0] e,
		input logic signed [SPEED_W-1:0] e1,
		input logic signed [SPEED_W-1:0] e2,
		input logic [GAIN_W-1:0] kp,
		input logic [GAIN_W-1:0] ki,
		input logic [GAIN_W-1:0] kd
	);
		logic signed [16:0] d1;
		logic signed [17:0] d2;
		prod_t r;
		d1 = 17'(e) - 17'(e1);
		d2 = 18'(e) - (18'(e1) <<< 1) + 18'(e2);
		r.p = $signed({1'b0, kp}) * d1;
		r.i = $signed({1'b0, ki}) * e;
		r.d = $signed({1'b0, kd}) * d2;
		return r;
	endfunction

	// acc*256 + inc, divided by 256 truncating toward zero, then saturated
	function automatic logic signed [ACC_W-1:0] acc_update(
		input logic signed [ACC_W-1:0] acc,
		input prod_t pr
	);
		logic signed [SUM_W-1:0] sum;
		logic signed [ACC_W:0] q;
		logic signed [ACC_W-1:0] r;
		sum = $signed({acc[ACC_W-1], acc, {FRAC_W{1'b0}}})
			+ SUM_W'(pr.p) + SUM_W'(pr.i) + SUM_W'(pr.d);
		q = (ACC_W+1)'(sum >>> FRAC_W);
		if (sum[SUM_W-1] && (|sum[FRAC_W-1:0])) begin
			q = q + (ACC_W+1)'(1);
		end
		if (q[ACC_W] != q[ACC_W-1]) begin
			r = q[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = q[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic duty_t drive_split(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] lim;
		logic signed [ACC_W-1:0] mag;
		duty_t r;
		lim = $signed(ACC_W'(DUTY_LIMIT));
		r.fwd = '0;
		r.rev = '0;
		if (acc > 0) begin
			mag = (acc > lim) ? lim : acc;
			r.fwd = mag[DUTY_W-1:0];
		end else begin
			mag = (acc < -lim) ? lim : -acc;
			r.rev = mag[DUTY_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/dual_incremental_pid_motor_drive.sv */
// a request accepted passes the stage-one input, stage-two product and output registers
// before m_tvalid; throughput: one request per cycle while m_tready is high; the
// accumulators close their loop in the second compute stage, the error history in the first
// arst_n clears all valid flags, accumulators and error history, and loads the
// setpoints and gains with their defaults
module dual_incremental_pid_motor_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // left_speed, right_speed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty
);

	logic signed [15:0] left_target_q, right_target_q;
	logic [15:0] left_kp_q, left_ki_q, left_kd_q;
	logic [15:0] right_kp_q, right_ki_q, right_kd_q;

	logic signed [15:0] left_err_prev_q, left_err_prev2_q;
	logic signed [15:0] right_err_prev_q, right_err_prev2_q;
	logic signed [31:0] left_acc_q, right_acc_q;

	logic valid_s1, valid_s2, out_valid_q;
	logic signed [15:0] left_speed_s1, right_speed_s1;
	dipid_pkg::prod_t left_prod_s2, right_prod_s2;
	logic [55:0] out_data_q;

	logic rdy_out, rdy2, rdy1, move1, move2;
	logic signed [15:0] left_err, right_err;
	logic signed [31:0] left_acc_next, right_acc_next;
	dipid_pkg::duty_t left_duty, right_duty;
	dipid_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx = dipid_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_target_q  <= 16'sd250;
			right_target_q <= 16'sd250;
			left_kp_q      <= 16'd2560;
			left_ki_q      <= 16'd2560;
			left_kd_q      <= 16'd0;
			right_kp_q     <= 16'd2560;
			right_ki_q     <= 16'd2560;
			right_kd_q     <= 16'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				dipid_pkg::REG_LEFT_TARGET:  left_target_q  <= pwdata[15:0];
				dipid_pkg::REG_RIGHT_TARGET: right_target_q <= pwdata[15:0];
				dipid_pkg::REG_LEFT_KP:      left_kp_q      <= pwdata[15:0];
				dipid_pkg::REG_LEFT_KI:      left_ki_q      <= pwdata[15:0];
				dipid_pkg::REG_LEFT_KD:      left_kd_q      <= pwdata[15:0];
				dipid_pkg::REG_RIGHT_KP:     right_kp_q     <= pwdata[15:0];
				dipid_pkg::REG_RIGHT_KI:     right_ki_q     <= pwdata[15:0];
				dipid_pkg::REG_RIGHT_KD:     right_kd_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			dipid_pkg::REG_LEFT_TARGET:  prdata = {16'd0, left_target_q};
			dipid_pkg::REG_RIGHT_TARGET: prdata = {16'd0, right_target_q};
			dipid_pkg::REG_LEFT_KP:      prdata = {16'd0, left_kp_q};
			dipid_pkg::REG_LEFT_KI:      prdata = {16'd0, left_ki_q};
			dipid_pkg::REG_LEFT_KD:      prdata = {16'd0, left_kd_q};
			dipid_pkg::REG_RIGHT_KP:     prdata = {16'd0, right_kp_q};
			dipid_pkg::REG_RIGHT_KI:     prdata = {16'd0, right_ki_q};
			dipid_pkg::REG_RIGHT_KD:     prdata = {16'd0, right_kd_q};
			default:                     prdata = '0;
		endcase
	end

	// each stage fills when it is empty or its contents move on
	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy2     = !valid_s2 || rdy_out;
	assign rdy1     = !valid_s1 || rdy2;
	assign move1    = valid_s1 && rdy2;
	assign move2    = valid_s2 && rdy_out;
	assign s_tready = rdy1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			left_speed_s1  <= s_tdata[15:0];
			right_speed_s1 <= s_tdata[31:16];
		end
	end

	// first stage: error and the three products per motor
	assign left_err  = left_target_q - left_speed_s1;
	assign right_err = right_target_q - right_speed_s1;

	always_ff @(posedge clk) begin
		if (move1) begin
			left_prod_s2 <= dipid_pkg::pid_products(left_err, left_err_prev_q,
				left_err_prev2_q, left_kp_q, left_ki_q, left_kd_q);
			right_prod_s2 <= dipid_pkg::pid_products(right_err, right_err_prev_q,
				right_err_prev2_q, right_kp_q, right_ki_q, right_kd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_err_prev_q   <= '0;
			left_err_prev2_q  <= '0;
			right_err_prev_q  <= '0;
			right_err_prev2_q <= '0;
		end else if (move1) begin
			left_err_prev2_q  <= left_err_prev_q;
			left_err_prev_q   <= left_err;
			right_err_prev2_q <= right_err_prev_q;
			right_err_prev_q  <= right_err;
		end
	end

	// second stage: accumulate, saturate, split into channels
	assign left_acc_next  = dipid_pkg::acc_update(left_acc_q, left_prod_s2);
	assign right_acc_next = dipid_pkg::acc_update(right_acc_q, right_prod_s2);
	assign left_duty      = dipid_pkg::drive_split(left_acc_next);
	assign right_duty     = dipid_pkg::drive_split(right_acc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_acc_q  <= '0;
			right_acc_q <= '0;
		end else if (move2) begin
			left_acc_q  <= left_acc_next;
			right_acc_q <= right_acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			out_data_q <= {right_duty.rev, right_duty.fwd, left_duty.rev, left_duty.fwd};
		end
	end

endmodule

/* hdl/dipid_checker.sv */
module dipid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	localparam logic [13:0] LIM = 14'(dipid_pkg::DUTY_LIMIT);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// only one channel of a motor is ever driven
	a_left_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] == 14'd0) || (m_tdata[27:14] == 14'd0))
		else $error("left motor driven both ways");

	a_right_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[41:28] == 14'd0) || (m_tdata[55:42] == 14'd0))
		else $error("right motor driven both ways");

	a_duty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] <= LIM) && (m_tdata[27:14] <= LIM)
			&& (m_tdata[41:28] <= LIM) && (m_tdata[55:42] <= LIM))
		else $error("duty above limit");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port not ready");

endmodule

bind dual_incremental_pid_motor_drive dipid_checker u_dipid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* bench/dual_incremental_pid_motor_drive_test.sv */
`timescale 1ns / 100ps

module dual_incremental_pid_motor_drive_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LATENCY     = 2;

	typedef struct packed {
		logic [dipid_pkg::DUTY_W-1:0] fwd;
		logic [dipid_pkg::DUTY_W-1:0] rev;
	} duty_pair_t;

	typedef struct packed {
		duty_pair_t right;
		duty_pair_t left;
	} duty_set_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // left_speed, right_speed
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty

	// controller state as the bench sees it, index 0 left, 1 right
	logic signed [15:0] target[2];
	logic [15:0]        gain_p[2];
	logic [15:0]        gain_i[2];
	logic [15:0]        gain_d[2];
	logic signed [31:0] drive_acc[2];
	logic signed [15:0] err_last[2];
	logic signed [15:0] err_older[2];

	logic [31:0] pending_ticks[$];
	duty_set_t   expected_duties[$];

	logic        in_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [31:0] ready_pattern = '1;
	int          ready_age = 0;
	int          errors = 0;
	int          cycle_count = 0;

	dual_incremental_pid_motor_drive dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	initial begin
		for (int m = 0; m < 2; m++) begin
			target[m]    = 16'sd250;
			gain_p[m]    = 16'd2560;
			gain_i[m]    = 16'd2560;
			gain_d[m]    = 16'd0;
			drive_acc[m] = '0;
			err_last[m]  = '0;
			err_older[m] = '0;
		end
	end

	function automatic duty_pair_t pid_tick(input int m, input logic [15:0] speed);
		logic signed [15:0] err;
		longint d1;
		longint d2;
		longint inc;
		longint q;
		longint mag;
		duty_pair_t r;
		err = target[m] - speed;
		d1  = longint'(err) - longint'(err_last[m]);
		d2  = longint'(err) - 2 * longint'(err_last[m]) + longint'(err_older[m]);
		inc = longint'(gain_p[m]) * d1 + longint'(gain_i[m]) * longint'(err)
			+ longint'(gain_d[m]) * d2;
		// division of signed integers truncates toward zero
		q = (longint'(drive_acc[m]) * 256 + inc) / 256;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		drive_acc[m] = q[31:0];
		err_older[m] = err_last[m];
		err_last[m]  = err;
		if (q > longint'(dipid_pkg::DUTY_LIMIT)) q = longint'(dipid_pkg::DUTY_LIMIT);
		if (q < -longint'(dipid_pkg::DUTY_LIMIT)) q = -longint'(dipid_pkg::DUTY_LIMIT);
		r = '0;
		if (q > 0) begin
			r.fwd = q[dipid_pkg::DUTY_W-1:0];
		end else begin
			mag = -q;
			r.rev = mag[dipid_pkg::DUTY_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	task automatic check_duty(input string name, input logic [dipid_pkg::DUTY_W-1:0] got,
			input logic [dipid_pkg::DUTY_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// request side: bursts of random length with gaps between them
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_ticks.size() > 0) begin
				s_tdata  <= pending_ticks.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: stall pattern rotated every cycle, swapped now and then
	always @(negedge clk) begin
		if (ready_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = $urandom();
				2: ready_pattern = $urandom() & $urandom();
				default: ready_pattern = $urandom() | $urandom();
			endcase
			if (ready_pattern == '0) ready_pattern = 32'h1;
			ready_age = $urandom_range(16, 96);
		end else begin
			ready_age--;
		end
		m_tready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
	end

	always @(posedge clk) begin
		duty_set_t want;
		duty_set_t got;
		in_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			want.left  = pid_tick(0, s_tdata[15:0]);
			want.right = pid_tick(1, s_tdata[31:16]);
			expected_duties.push_back(want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.left.fwd  = m_tdata[13:0];
			got.left.rev  = m_tdata[27:14];
			got.right.fwd = m_tdata[41:28];
			got.right.rev = m_tdata[55:42];
			if (expected_duties.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_duties.pop_front();
				check_duty("left_fwd_duty", got.left.fwd, want.left.fwd);
				check_duty("left_rev_duty", got.left.rev, want.left.rev);
				check_duty("right_fwd_duty", got.right.fwd, want.right.fwd);
				check_duty("right_rev_duty", got.right.rev, want.right.rev);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic reg_write(input dipid_pkg::reg_idx_t idx, input logic [15:0] value);
		logic [31:0] word;
		// upper bits carry noise, only the low half counts
		word = $urandom();
		word[15:0] = value;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			dipid_pkg::REG_LEFT_TARGET:  target[0] = value;
			dipid_pkg::REG_RIGHT_TARGET: target[1] = value;
			dipid_pkg::REG_LEFT_KP:      gain_p[0] = value;
			dipid_pkg::REG_LEFT_KI:      gain_i[0] = value;
			dipid_pkg::REG_LEFT_KD:      gain_d[0] = value;
			dipid_pkg::REG_RIGHT_KP:     gain_p[1] = value;
			dipid_pkg::REG_RIGHT_KI:     gain_i[1] = value;
			dipid_pkg::REG_RIGHT_KD:     gain_d[1] = value;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_settings(input logic [15:0] lt, input logic [15:0] rt,
			input logic [15:0] lp, input logic [15:0] li, input logic [15:0] ld,
			input logic [15:0] rp, input logic [15:0] ri, input logic [15:0] rd);
		reg_write(dipid_pkg::REG_LEFT_TARGET, lt);
		reg_write(dipid_pkg::REG_RIGHT_TARGET, rt);
		reg_write(dipid_pkg::REG_LEFT_KP, lp);
		reg_write(dipid_pkg::REG_LEFT_KI, li);
		reg_write(dipid_pkg::REG_LEFT_KD, ld);
		reg_write(dipid_pkg::REG_RIGHT_KP, rp);
		reg_write(dipid_pkg::REG_RIGHT_KI, ri);
		reg_write(dipid_pkg::REG_RIGHT_KD, rd);
	endtask

	task automatic queue_tick(input logic [15:0] left_speed, input logic [15:0] right_speed);
		pending_ticks.push_back({right_speed, left_speed});
	endtask

	task automatic drain_results();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || s_tvalid || expected_duties.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3: return 16'($urandom_range(0, 4096));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_speed(input int m, input int spread);
		if ($urandom_range(0, 9) < 7) begin
			return 16'(int'(target[m]) + int'($urandom_range(0, 2 * spread)) - spread);
		end
		return 16'($urandom());
	endfunction

	initial begin
		int spread;
		int half;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero drive first, then wrapping errors and bit patterns
		queue_tick(16'd250, 16'd250);
		queue_tick(16'h0000, 16'h0000);
		queue_tick(16'h7fff, 16'h8000);
		queue_tick(16'h8000, 16'h7fff);
		queue_tick(16'h8000, 16'h8000);
		queue_tick(16'h7fff, 16'h7fff);
		queue_tick(16'hffff, 16'h0001);
		queue_tick(16'h0001, 16'hffff);
		queue_tick(16'd251, 16'd249);
		queue_tick(16'd249, 16'd251);
		queue_tick(16'h5555, 16'haaaa);
		queue_tick(16'haaaa, 16'h5555);
		queue_tick(16'd250, 16'd250);
		queue_tick(16'd1000, 16'hfc18);
		queue_tick(16'd250, 16'd250);
		queue_tick(16'd260, 16'd240);
		queue_tick(16'd250, 16'd250);
		queue_tick(16'h8000, 16'h0000);
		queue_tick(16'h0000, 16'h8000);
		queue_tick(16'd250, 16'd250);
		drain_results();

		// zero gains and extreme setpoints: the drive must hold
		load_settings(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000);
		for (int n = 0; n < 60; n++) queue_tick(16'($urandom()), 16'($urandom()));
		drain_results();

		// full gains with a steady large error drive the accumulators to their bounds
		load_settings(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 16'hffff);
		for (int n = 0; n < 300; n++) begin
			queue_tick(16'($urandom_range(0, 40)), 16'(-int'($urandom_range(0, 40))));
		end
		drain_results();
		load_settings(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 16'hffff);
		for (int n = 0; n < 600; n++) begin
			queue_tick(16'(-int'($urandom_range(0, 40))), 16'($urandom_range(0, 40)));
		end
		drain_results();

		for (int phase = 0; phase < 9; phase++) begin
			load_settings(pick_target(), pick_target(), pick_gain(), pick_gain(), pick_gain(),
				pick_gain(), pick_gain(), pick_gain());
			spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 500);
			half = $urandom_range(20, 70);
			for (int n = 0; n < 90; n++) begin
				// hold the sender until everything in flight has come back
				if (n == half) drain_results();
				queue_tick(pick_speed(0, spread), pick_speed(1, spread));
			end
			drain_results();
		end

		if (expected_duties.size() != 0) begin
			report_mismatch($sformatf("%0d results never came", expected_duties.size()));
		end
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/dipid_pkg.sv
hdl/dual_incremental_pid_motor_drive.sv
hdl/dipid_checker.sv
bench/dual_incremental_pid_motor_drive_test.sv
